/* rtl/cht_pkg.sv */
// Shared types, constants and hash functions for the two-way cuckoo hash store.
// Used by cht_ctrl, cht_dpath and cuckoo_hash_table_core; no dependencies.
package cht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(2 * TABLE_DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int KICK_W = 8;
    localparam int ENTRY_W = 12;
    localparam int OP_W = 2;
    localparam int STATUS_W = 3;
    localparam int OUT_DATA_W = 48;
    localparam int SLOT_TWO_SHIFT = 16;

    localparam logic [KEY_W-1:0] EMPTY_SLOT = '1;
    localparam logic [KICK_W-1:0] KICKS_RESET = 8'd100;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_MISSING  = 3'd2,
        ST_FAILED   = 3'd3,
        ST_REJECTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_KICK1,
        S_KICK2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    clr_wr;
        logic    latch;
        logic    k1;
        logic    k2;
        logic    del1;
        logic    del2;
        logic    count_up;
        logic    count_dn;
        logic    set_status;
        status_t status;
        logic    load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            reject;
        logic            match1;
        logic            match2;
        logic            rd1_empty;
        logic            rd2_empty;
        logic            kicks_zero;
        logic            last_round;
        logic            clr_last;
        logic            out_free;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] slot_one(input logic [KEY_W-1:0] k);
        return k[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_two(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] sh;
        sh = k >> SLOT_TWO_SHIFT;
        return sh[IDX_W-1:0];
    endfunction

endpackage

/* rtl/cht_ctrl.sv */
// Controller state machine for the cuckoo hash store: clearing pass, lookup,
// eviction rounds and result hand-off. Depends on cht_pkg.
module cht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  cht_pkg::dp_stat_t stat,
    output cht_pkg::ctl_cmd_t cmd
);

    cht_pkg::state_t state_reg;
    cht_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cht_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.status = cht_pkg::ST_DONE;
        s_axis_tready = 1'b0;
        case (state_reg)
            cht_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = cht_pkg::S_IDLE;
                end
            end
            cht_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.latch = 1'b1;
                    state_next = cht_pkg::S_LOOK;
                end
            end
            cht_pkg::S_LOOK:
            begin
                state_next = cht_pkg::S_DONE;
                cmd.set_status = 1'b1;
                if (stat.reject)
                begin
                    cmd.status = cht_pkg::ST_REJECTED;
                end
                else
                begin
                    case (stat.op)
                        cht_pkg::OP_INSERT:
                        begin
                            if (stat.match1 || stat.match2)
                            begin
                                cmd.status = cht_pkg::ST_PRESENT;
                            end
                            else if (stat.kicks_zero)
                            begin
                                cmd.status = cht_pkg::ST_FAILED;
                            end
                            else
                            begin
                                cmd.k1 = 1'b1;
                                if (stat.rd1_empty)
                                begin
                                    cmd.count_up = 1'b1;
                                end
                                else
                                begin
                                    cmd.set_status = 1'b0;
                                    state_next = cht_pkg::S_KICK2;
                                end
                            end
                        end
                        cht_pkg::OP_SEARCH:
                        begin
                            if (!(stat.match1 || stat.match2))
                            begin
                                cmd.status = cht_pkg::ST_MISSING;
                            end
                        end
                        cht_pkg::OP_DELETE:
                        begin
                            if (stat.match1)
                            begin
                                cmd.del1 = 1'b1;
                                cmd.count_dn = 1'b1;
                            end
                            else if (stat.match2)
                            begin
                                cmd.del2 = 1'b1;
                                cmd.count_dn = 1'b1;
                            end
                            else
                            begin
                                cmd.status = cht_pkg::ST_MISSING;
                            end
                        end
                        default:
                        begin
                            cmd.status = cht_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            cht_pkg::S_KICK1:
            begin
                cmd.k1 = 1'b1;
                if (stat.rd1_empty)
                begin
                    cmd.count_up = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next = cht_pkg::S_DONE;
                end
                else
                begin
                    state_next = cht_pkg::S_KICK2;
                end
            end
            cht_pkg::S_KICK2:
            begin
                cmd.k2 = 1'b1;
                if (stat.rd2_empty)
                begin
                    cmd.count_up = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next = cht_pkg::S_DONE;
                end
                else if (stat.last_round)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = cht_pkg::ST_FAILED;
                    state_next = cht_pkg::S_DONE;
                end
                else
                begin
                    state_next = cht_pkg::S_KICK1;
                end
            end
            cht_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = cht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/cht_dpath.sv */
// Datapath for the cuckoo hash store: both slot tables, key in hand, kick counter,
// entry counter, kick limit register and output register. Depends on cht_pkg.
module cht_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [cht_pkg::KICK_W-1:0]          cfg_wdata,
    input  logic [cht_pkg::KEY_W-1:0]           s_axis_tdata,
    input  logic [cht_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cht_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [cht_pkg::STATUS_W-1:0]        m_axis_tuser,
    input  cht_pkg::ctl_cmd_t                   cmd,
    output cht_pkg::dp_stat_t                   stat
);

    logic [cht_pkg::KEY_W-1:0] first_table [cht_pkg::TABLE_DEPTH];
    logic [cht_pkg::KEY_W-1:0] second_table [cht_pkg::TABLE_DEPTH];

    logic [cht_pkg::KEY_W-1:0]      rd1_reg;
    logic [cht_pkg::KEY_W-1:0]      rd2_reg;
    logic [cht_pkg::KEY_W-1:0]      hand_reg;
    logic [cht_pkg::OP_W-1:0]       op_reg;
    logic [cht_pkg::KICK_W-1:0]     round_reg;
    logic [cht_pkg::KICK_W-1:0]     round_next;
    logic [cht_pkg::KICK_W-1:0]     max_kicks_reg;
    logic [cht_pkg::IDX_W-1:0]      clr_addr_reg;
    logic [cht_pkg::CNT_W-1:0]      count_reg;
    cht_pkg::status_t               status_reg;
    logic [cht_pkg::KEY_W-1:0]      homeless_reg;
    logic                           out_valid_reg;
    logic [cht_pkg::STATUS_W-1:0]   out_status_reg;
    logic [cht_pkg::KEY_W-1:0]      out_homeless_reg;
    logic [cht_pkg::ENTRY_W-1:0]    out_count_reg;

    logic [cht_pkg::IDX_W-1:0]      raddr1;
    logic [cht_pkg::IDX_W-1:0]      raddr2;
    logic                           we1;
    logic                           we2;
    logic [cht_pkg::IDX_W-1:0]      waddr1;
    logic [cht_pkg::IDX_W-1:0]      waddr2;
    logic [cht_pkg::KEY_W-1:0]      wdata1;
    logic [cht_pkg::KEY_W-1:0]      wdata2;

    always_comb
    begin
        raddr1 = cmd.k2 ? cht_pkg::slot_one(rd2_reg) : cht_pkg::slot_one(s_axis_tdata);
        raddr2 = cmd.k1 ? cht_pkg::slot_two(rd1_reg) : cht_pkg::slot_two(s_axis_tdata);

        we1 = cmd.clr_wr || cmd.k1 || cmd.del1;
        waddr1 = cmd.clr_wr ? clr_addr_reg : cht_pkg::slot_one(hand_reg);
        wdata1 = cmd.k1 ? hand_reg : cht_pkg::EMPTY_SLOT;

        we2 = cmd.clr_wr || cmd.k2 || cmd.del2;
        waddr2 = cmd.clr_wr ? clr_addr_reg : cht_pkg::slot_two(hand_reg);
        wdata2 = cmd.k2 ? hand_reg : cht_pkg::EMPTY_SLOT;

        round_next = round_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            first_table[waddr1] <= wdata1;
        end
        rd1_reg <= first_table[raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (we2)
        begin
            second_table[waddr2] <= wdata2;
        end
        rd2_reg <= second_table[raddr2];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            hand_reg <= s_axis_tdata;
            op_reg <= s_axis_tuser;
        end
        else if (cmd.k1)
        begin
            hand_reg <= rd1_reg;
        end
        else if (cmd.k2)
        begin
            hand_reg <= rd2_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
            if (cmd.status == cht_pkg::ST_FAILED)
            begin
                homeless_reg <= cmd.k2 ? rd2_reg : hand_reg;
            end
            else
            begin
                homeless_reg <= cht_pkg::EMPTY_SLOT;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_homeless_reg <= homeless_reg;
            out_count_reg <= cht_pkg::ENTRY_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            max_kicks_reg <= cht_pkg::KICKS_RESET;
            clr_addr_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                round_reg <= '0;
            end
            else if (cmd.k2)
            begin
                round_reg <= round_next;
            end
            if (cfg_wen)
            begin
                max_kicks_reg <= cfg_wdata;
            end
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.count_up)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.count_dn)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op = op_reg;
        stat.reject = (hand_reg == cht_pkg::EMPTY_SLOT) ||
                      !(op_reg inside {cht_pkg::OP_INSERT, cht_pkg::OP_SEARCH,
                                       cht_pkg::OP_DELETE});
        stat.match1 = (rd1_reg == hand_reg);
        stat.match2 = (rd2_reg == hand_reg);
        stat.rd1_empty = (rd1_reg == cht_pkg::EMPTY_SLOT);
        stat.rd2_empty = (rd2_reg == cht_pkg::EMPTY_SLOT);
        stat.kicks_zero = (max_kicks_reg == '0);
        stat.last_round = (round_next == max_kicks_reg);
        stat.clr_last = (clr_addr_reg == cht_pkg::LAST_IDX);
        stat.out_free = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tdata = {{(cht_pkg::OUT_DATA_W - cht_pkg::KEY_W - cht_pkg::ENTRY_W){1'b0}},
                           out_count_reg, out_homeless_reg};

endmodule

/* rtl/cuckoo_hash_table_core.sv */
// Two-way cuckoo hash store for 32-bit keys: insert, search and delete.
// One item is in work at a time, and a finished result waits in an output register while
// m_axis_tready is low. An insert that displaces keys writes at most 2 * max_kicks slots.
// After reset a clearing pass writes all 1024 slots of both tables empty before any item.
module cuckoo_hash_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // homeless_key, entry_count, zero fill
    output logic [2:0]  m_axis_tuser    // status
);

    cht_pkg::ctl_cmd_t cmd;
    cht_pkg::dp_stat_t stat;

    cht_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    cht_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

/* tb/tb_cuckoo_hash_table_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cuckoo_hash_table_core: directed and random insert, search and
// delete traffic against an in-bench model of both tables, across several kick limits.
// Depends on cht_pkg and the cuckoo_hash_table_core RTL.
module tb_cuckoo_hash_table_core;

    localparam logic [cht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        cht_pkg::status_t                status;
        logic [cht_pkg::KEY_W-1:0]       homeless;
        logic [cht_pkg::ENTRY_W-1:0]     count;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wen;
    logic [7:0]        cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;

    logic [cht_pkg::KEY_W-1:0]  tbl_one [cht_pkg::TABLE_DEPTH];
    logic [cht_pkg::KEY_W-1:0]  tbl_two [cht_pkg::TABLE_DEPTH];
    int unsigned                key_total;
    logic [cht_pkg::KICK_W-1:0] kick_limit;
    reply_t                     replies_due[$];
    logic [cht_pkg::KEY_W-1:0]  known_keys[$];
    reply_t                     want;
    int                         errors;
    int                         quiet_cycles;
    bit                         gaps_on;

    cuckoo_hash_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit key_stored(logic [cht_pkg::KEY_W-1:0] key);
        return tbl_one[key % cht_pkg::TABLE_DEPTH] == key ||
               tbl_two[(key >> 16) % cht_pkg::TABLE_DEPTH] == key;
    endfunction

    function automatic reply_t cuckoo_apply(logic [cht_pkg::OP_W-1:0] op,
                                            logic [cht_pkg::KEY_W-1:0] key);
        reply_t                    rep;
        logic [cht_pkg::KEY_W-1:0] hand;
        logic [cht_pkg::KEY_W-1:0] bumped;
        int unsigned               p1;
        int unsigned               p2;
        bit                        placed;
        rep.status = cht_pkg::ST_DONE;
        rep.homeless = cht_pkg::EMPTY_SLOT;
        if (key == cht_pkg::EMPTY_SLOT || op == OP_UNUSED)
        begin
            rep.status = cht_pkg::ST_REJECTED;
        end
        else if (op == cht_pkg::OP_INSERT)
        begin
            if (key_stored(key))
            begin
                rep.status = cht_pkg::ST_PRESENT;
            end
            else
            begin
                hand = key;
                placed = 1'b0;
                for (int r = 0; r < kick_limit && !placed; r++)
                begin
                    p1 = hand % cht_pkg::TABLE_DEPTH;
                    bumped = tbl_one[p1];
                    tbl_one[p1] = hand;
                    if (bumped == cht_pkg::EMPTY_SLOT)
                    begin
                        placed = 1'b1;
                    end
                    else
                    begin
                        hand = bumped;
                        p2 = (hand >> 16) % cht_pkg::TABLE_DEPTH;
                        bumped = tbl_two[p2];
                        tbl_two[p2] = hand;
                        if (bumped == cht_pkg::EMPTY_SLOT)
                            placed = 1'b1;
                        else
                            hand = bumped;
                    end
                end
                if (placed)
                begin
                    key_total++;
                end
                else
                begin
                    rep.status = cht_pkg::ST_FAILED;
                    rep.homeless = hand;
                end
            end
        end
        else if (op == cht_pkg::OP_SEARCH)
        begin
            rep.status = key_stored(key) ? cht_pkg::ST_DONE : cht_pkg::ST_MISSING;
        end
        else
        begin
            p1 = key % cht_pkg::TABLE_DEPTH;
            p2 = (key >> 16) % cht_pkg::TABLE_DEPTH;
            if (tbl_one[p1] == key)
            begin
                tbl_one[p1] = cht_pkg::EMPTY_SLOT;
                key_total--;
            end
            else if (tbl_two[p2] == key)
            begin
                tbl_two[p2] = cht_pkg::EMPTY_SLOT;
                key_total--;
            end
            else
            begin
                rep.status = cht_pkg::ST_MISSING;
            end
        end
        rep.count = key_total[cht_pkg::ENTRY_W-1:0];
        return rep;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [cht_pkg::OP_W-1:0] op, logic [cht_pkg::KEY_W-1:0] key);
        int gap;
        int roll;
        gap = 0;
        if (gaps_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                gap = $urandom_range(10, 40);
            else if (roll < 40)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = key;
        s_axis_tuser = op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        replies_due.push_back(cuckoo_apply(op, key));
        if (op == cht_pkg::OP_INSERT && key != cht_pkg::EMPTY_SLOT)
        begin
            known_keys.push_back(key);
            if (known_keys.size() > 48)
                void'(known_keys.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid = 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_kick_limit(logic [cht_pkg::KICK_W-1:0] value);
        cfg_wen = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        kick_limit = value;
    endtask

    function automatic logic [cht_pkg::KEY_W-1:0] crowded_key(int span);
        logic [cht_pkg::KEY_W-1:0] k;
        k = $urandom;
        k[9:0] = 10'($urandom_range(0, span - 1));
        k[25:16] = 10'($urandom_range(0, span - 1));
        return k;
    endfunction

    task automatic test_directed();
        write_kick_limit(cht_pkg::KICKS_RESET);
        send_item(cht_pkg::OP_SEARCH, 32'h0000_1234);
        send_item(cht_pkg::OP_DELETE, 32'h0000_1234);
        send_item(cht_pkg::OP_INSERT, 32'h0000_0000);
        send_item(cht_pkg::OP_INSERT, 32'h0000_0000);
        send_item(cht_pkg::OP_SEARCH, 32'h0000_0000);
        wait_for_replies();
        send_item(cht_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_item(cht_pkg::OP_INSERT, 32'h8000_0000);
        send_item(cht_pkg::OP_INSERT, 32'hFFFF_FFFE);
        send_item(cht_pkg::OP_INSERT, 32'h0001_0000);
        send_item(cht_pkg::OP_INSERT, 32'h0002_0000);
        send_item(cht_pkg::OP_INSERT, 32'h0003_0000);
        wait_for_replies();
        send_item(cht_pkg::OP_SEARCH, 32'h0000_0000);
        send_item(cht_pkg::OP_DELETE, 32'h0000_0000);
        send_item(cht_pkg::OP_DELETE, 32'h0003_0000);
        send_item(cht_pkg::OP_SEARCH, 32'h0000_0000);
        send_item(cht_pkg::OP_INSERT, cht_pkg::EMPTY_SLOT);
        send_item(cht_pkg::OP_SEARCH, cht_pkg::EMPTY_SLOT);
        send_item(cht_pkg::OP_DELETE, cht_pkg::EMPTY_SLOT);
        send_item(OP_UNUSED, 32'h0000_0005);
        send_item(cht_pkg::OP_DELETE, 32'h8000_0000);
        send_item(cht_pkg::OP_SEARCH, 32'hFFFF_FFFE);
        wait_for_replies();
    endtask

    task automatic test_kick_limits();
        write_kick_limit(8'd0);
        send_item(cht_pkg::OP_INSERT, 32'h0000_0055);
        send_item(cht_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_item(cht_pkg::OP_SEARCH, 32'h0000_0055);
        wait_for_replies();
        write_kick_limit(8'd1);
        send_item(cht_pkg::OP_INSERT, 32'h0000_0100);
        send_item(cht_pkg::OP_INSERT, 32'h0001_0100);
        send_item(cht_pkg::OP_INSERT, 32'h0002_0100);
        send_item(cht_pkg::OP_SEARCH, 32'h0001_0000);
        send_item(cht_pkg::OP_SEARCH, 32'h0001_0100);
        wait_for_replies();
    endtask

    task automatic test_mixed_traffic(int items, logic [cht_pkg::KICK_W-1:0] kicks, int span,
                                      bit gaps);
        int                        roll;
        logic [cht_pkg::OP_W-1:0]  op;
        logic [cht_pkg::KEY_W-1:0] key;
        write_kick_limit(kicks);
        gaps_on = gaps;
        for (int n = 0; n < items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                op = cht_pkg::OP_W'($urandom_range(0, 3));
                key = ($urandom_range(0, 15) == 0) ? cht_pkg::EMPTY_SLOT :
                                                     cht_pkg::KEY_W'($urandom);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    op = cht_pkg::OP_INSERT;
                else if (roll < 72)
                    op = cht_pkg::OP_SEARCH;
                else
                    op = cht_pkg::OP_DELETE;
                if (known_keys.size() != 0 && $urandom_range(0, 99) < 60)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    key = crowded_key(span);
            end
            send_item(op, key);
        end
        wait_for_replies();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int stall_left;
        int roll;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (gaps_on)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4)
                        stall_left = $urandom_range(10, 40);
                    else if (roll < 25)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata[31:0] !== want.homeless)
                begin
                    errors++;
                    $display("%0t: homeless_key mismatch: expected %h, actual %h",
                             $time, want.homeless, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[43:32] !== want.count)
                begin
                    errors++;
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.count, m_axis_tdata[43:32]);
                end
                if (m_axis_tdata[47:44] !== 4'd0)
                begin
                    errors++;
                    $display("%0t: fill bits mismatch: expected 0, actual %h",
                             $time, m_axis_tdata[47:44]);
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("cuckoo_hash_table_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        gaps_on = 1'b1;
        for (int i = 0; i < cht_pkg::TABLE_DEPTH; i++)
        begin
            tbl_one[i] = cht_pkg::EMPTY_SLOT;
            tbl_two[i] = cht_pkg::EMPTY_SLOT;
        end
        key_total = 0;
        kick_limit = cht_pkg::KICKS_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_kick_limits();
        test_mixed_traffic(200, 8'd255, 32, 1'b1);
        test_mixed_traffic(400, 8'd1, 8, 1'b1);
        test_mixed_traffic(400, cht_pkg::KICK_W'($urandom_range(2, 40)), 16, 1'b1);
        test_mixed_traffic(300, 8'd7, 12, 1'b0);
        test_mixed_traffic(300, 8'd100, 24, 1'b1);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("cuckoo_hash_table_core test passed");
        else
            $display("cuckoo_hash_table_core test failed");
        $finish;
    end

endmodule
